>>> rtl/nwh_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the arctangent table for the nearest waypoint heading block.
// No dependencies; every other file but nwh_ram takes its names from here by scope.
package nwh_pkg;

   localparam int MAX_POINTS   = 64;
   localparam int ADDR_W       = $clog2(MAX_POINTS);
   localparam int COUNT_W      = 7;
   localparam int MIN_POINTS   = 2;
   localparam int INDEX_W      = 6;
   localparam int COORD_W      = 20;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int DIST_W       = 2 * DIFF_W;
   localparam int HEADING_W    = 16;
   localparam int SEG_W        = 6;
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int PRESCALE     = 8;
   localparam int VEC_W        = 32;
   localparam int ANGLE_W      = 22;
   localparam int HALF_TURN    = 1 << 19;
   localparam int ROUND_SHIFT  = 4;
   localparam int ROUND_BIAS   = 1 << (ROUND_SHIFT - 1);
   localparam int DRAIN_CYCLES = 3;
   localparam int DRAIN_W      = $clog2(DRAIN_CYCLES + 1);

   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_QUERY   = 1'b1;
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_FEW = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic [DIST_W-1:0]         dist_type;
   typedef logic signed [VEC_W-1:0]   vec_type;
   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic [ADDR_W-1:0]         addr_type;
   typedef logic [STEP_W-1:0]         step_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_SCAN,
      RD_START,
      RD_END
   } rd_kind_type;

   typedef struct packed {
      logic        wr_en;
      logic        capture_pose;
      logic        scan_clear;
      rd_kind_type rd_kind;
      addr_type    rd_addr;
      logic        cordic_init;
      logic        cordic_step;
      step_type    step;
      logic        load_out;
      logic        few;
   } cmd_type;

   typedef struct packed {
      addr_type seg_start;
   } dp_stat_type;

   // atan(2^-i) in turn/2^20
   function automatic angle_type atan_turns(input step_type step);
      angle_type r;
      unique case (step)
         4'd0:  r = angle_type'(131072);
         4'd1:  r = angle_type'(77376);
         4'd2:  r = angle_type'(40884);
         4'd3:  r = angle_type'(20753);
         4'd4:  r = angle_type'(10417);
         4'd5:  r = angle_type'(5213);
         4'd6:  r = angle_type'(2607);
         4'd7:  r = angle_type'(1304);
         4'd8:  r = angle_type'(652);
         4'd9:  r = angle_type'(326);
         4'd10: r = angle_type'(163);
         4'd11: r = angle_type'(81);
         4'd12: r = angle_type'(41);
         4'd13: r = angle_type'(20);
         4'd14: r = angle_type'(10);
         4'd15: r = angle_type'(5);
      endcase
      return r;
   endfunction

endpackage

>>> rtl/nwh_req_if.sv
`timescale 1ns / 1ps
// Request channel: waypoint write and pose query transactions.
// Depends on nwh_pkg for field widths and types.
interface nwh_req_if;
   logic                            valid;
   logic                            ready;
   logic                            opcode;
   logic [nwh_pkg::INDEX_W-1:0]     point_index;
   nwh_pkg::coord_type              point_x;
   nwh_pkg::coord_type              point_y;
   nwh_pkg::coord_type              pose_x;
   nwh_pkg::coord_type              pose_y;

   modport source (output valid, opcode, point_index, point_x, point_y, pose_x, pose_y,
                   input ready);
   modport sink (input valid, opcode, point_index, point_x, point_y, pose_x, pose_y,
                 output ready);
endinterface

>>> rtl/nwh_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: heading, segment start and status of one query transaction.
// Depends on nwh_pkg for field widths.
interface nwh_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [nwh_pkg::HEADING_W-1:0] heading;
   logic [nwh_pkg::SEG_W-1:0]     segment_start;
   logic                          status;

   modport source (output valid, heading, segment_start, status, input ready);
   modport sink (input valid, heading, segment_start, status, output ready);
endinterface

>>> rtl/nwh_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM, one write port and one read port with registered read data.
// No dependencies.
module nwh_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/nwh_datapath.sv
`timescale 1ns / 1ps
// Datapath: waypoint store, distance pipeline with running minimum, CORDIC vectoring
// unit and result register. Depends on nwh_pkg and nwh_ram; driven by nwh_ctrl commands.
module nwh_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  nwh_pkg::cmd_type                cmd,
   input  logic [nwh_pkg::INDEX_W-1:0]     req_point_index,
   input  nwh_pkg::coord_type              req_point_x,
   input  nwh_pkg::coord_type              req_point_y,
   input  nwh_pkg::coord_type              req_pose_x,
   input  nwh_pkg::coord_type              req_pose_y,
   output nwh_pkg::dp_stat_type            dp_stat,
   output logic [nwh_pkg::HEADING_W-1:0]   heading,
   output logic [nwh_pkg::SEG_W-1:0]       segment_start,
   output logic                            status
);

   logic                                ram_wr_en;
   nwh_pkg::addr_type                   ram_wr_addr;
   logic [2*nwh_pkg::COORD_W-1:0]       ram_rd_data;
   nwh_pkg::coord_type                  rd_x;
   nwh_pkg::coord_type                  rd_y;

   nwh_pkg::coord_type                  pose_x_ff;
   nwh_pkg::coord_type                  pose_y_ff;
   nwh_pkg::rd_kind_type                rd_kind_ff;
   nwh_pkg::addr_type                   rd_idx_ff;

   nwh_pkg::diff_type                   ex_in, ey_in, ex_ff, ey_ff;
   logic                                s2_valid_ff;
   nwh_pkg::addr_type                   s2_idx_ff;
   logic signed [nwh_pkg::DIST_W-1:0]   sqx_in, sqy_in;
   nwh_pkg::dist_type                   sqx_ff, sqy_ff;
   logic                                s3_valid_ff;
   nwh_pkg::addr_type                   s3_idx_ff;
   nwh_pkg::dist_type                   dist_in;
   logic                                better_in;
   logic                                have_ff;
   nwh_pkg::dist_type                   best_d_ff;
   nwh_pkg::addr_type                   best_idx_ff;
   nwh_pkg::addr_type                   seg_start_in;

   nwh_pkg::coord_type                  p0x_ff, p0y_ff;
   nwh_pkg::diff_type                   dx_in, dy_in, dx_ff, dy_ff;
   logic                                neg_dir;
   nwh_pkg::diff_type                   adx, ady;
   nwh_pkg::vec_type                    x_in, y_in, x_ff, y_ff, xs, ys;
   nwh_pkg::angle_type                  z_in, z_ff, zr;
   logic                                zero_in, zero_ff;

   logic [nwh_pkg::HEADING_W-1:0]       heading_ff;
   logic [nwh_pkg::SEG_W-1:0]           seg_ff;
   logic                                status_ff;

   assign ram_wr_en   = cmd.wr_en && (int'(req_point_index) < nwh_pkg::MAX_POINTS);
   assign ram_wr_addr = nwh_pkg::ADDR_W'(req_point_index);

   nwh_ram #(
      .WIDTH (2 * nwh_pkg::COORD_W),
      .DEPTH (nwh_pkg::MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data ({req_point_x, req_point_y}),
      .rd_addr (cmd.rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_x = nwh_pkg::coord_type'(ram_rd_data[2*nwh_pkg::COORD_W-1:nwh_pkg::COORD_W]);
   assign rd_y = nwh_pkg::coord_type'(ram_rd_data[nwh_pkg::COORD_W-1:0]);

   always_comb begin
      ex_in     = nwh_pkg::diff_type'(rd_x) - nwh_pkg::diff_type'(pose_x_ff);
      ey_in     = nwh_pkg::diff_type'(rd_y) - nwh_pkg::diff_type'(pose_y_ff);
      sqx_in    = ex_ff * ex_ff;
      sqy_in    = ey_ff * ey_ff;
      dist_in   = sqx_ff + sqy_ff;
      better_in = s3_valid_ff && (!have_ff || (dist_in < best_d_ff));
      seg_start_in = (best_idx_ff == '0) ? '0 : best_idx_ff - nwh_pkg::ADDR_W'(1);
      dx_in     = nwh_pkg::diff_type'(rd_x) - nwh_pkg::diff_type'(p0x_ff);
      dy_in     = nwh_pkg::diff_type'(rd_y) - nwh_pkg::diff_type'(p0y_ff);
   end

   // fold into the right half plane, then rotate towards the x axis
   always_comb begin
      neg_dir = dx_ff[nwh_pkg::DIFF_W-1];
      adx     = neg_dir ? -dx_ff : dx_ff;
      ady     = neg_dir ? -dy_ff : dy_ff;
      zero_in = (dx_ff == '0) && (dy_ff == '0);
      xs      = x_ff >>> cmd.step;
      ys      = y_ff >>> cmd.step;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (cmd.cordic_init) begin
         x_in = nwh_pkg::vec_type'(adx) <<< nwh_pkg::PRESCALE;
         y_in = nwh_pkg::vec_type'(ady) <<< nwh_pkg::PRESCALE;
         z_in = neg_dir ? nwh_pkg::angle_type'(nwh_pkg::HALF_TURN) : '0;
      end else if (cmd.cordic_step) begin
         if (!y_ff[nwh_pkg::VEC_W-1]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + nwh_pkg::atan_turns(cmd.step);
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - nwh_pkg::atan_turns(cmd.step);
         end
      end
      zr = z_ff + nwh_pkg::angle_type'(nwh_pkg::ROUND_BIAS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_kind_ff  <= nwh_pkg::RD_NONE;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         have_ff     <= 1'b0;
      end else begin
         rd_kind_ff  <= cmd.rd_kind;
         s2_valid_ff <= (rd_kind_ff == nwh_pkg::RD_SCAN);
         s3_valid_ff <= s2_valid_ff;
         if (cmd.scan_clear) begin
            have_ff <= 1'b0;
         end else if (better_in) begin
            have_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= cmd.rd_addr;
      s2_idx_ff <= rd_idx_ff;
      s3_idx_ff <= s2_idx_ff;
      ex_ff     <= ex_in;
      ey_ff     <= ey_in;
      sqx_ff    <= nwh_pkg::dist_type'(sqx_in);
      sqy_ff    <= nwh_pkg::dist_type'(sqy_in);
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      if (cmd.capture_pose) begin
         pose_x_ff <= req_pose_x;
         pose_y_ff <= req_pose_y;
      end
      if (better_in && !cmd.scan_clear) begin
         best_d_ff   <= dist_in;
         best_idx_ff <= s3_idx_ff;
      end
      if (rd_kind_ff == nwh_pkg::RD_START) begin
         p0x_ff <= rd_x;
         p0y_ff <= rd_y;
      end
      if (rd_kind_ff == nwh_pkg::RD_END) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (cmd.cordic_init) begin
         zero_ff <= zero_in;
      end
      if (cmd.load_out) begin
         heading_ff <= (cmd.few || zero_ff) ? '0 : zr[nwh_pkg::ROUND_SHIFT +: nwh_pkg::HEADING_W];
         seg_ff     <= cmd.few ? '0 : nwh_pkg::SEG_W'(seg_start_in);
         status_ff  <= cmd.few ? nwh_pkg::STATUS_FEW : nwh_pkg::STATUS_OK;
      end
   end

   assign dp_stat.seg_start = seg_start_in;
   assign heading           = heading_ff;
   assign segment_start     = seg_ff;
   assign status            = status_ff;

endmodule

>>> rtl/nwh_ctrl.sv
`timescale 1ns / 1ps
// Controller: point count register, request/response handshake and the sequencer that
// steps the datapath through scan, segment fetch and CORDIC. Depends on nwh_pkg.
module nwh_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [nwh_pkg::COUNT_W-1:0]   csr_wr_data,
   input  logic                          req_valid,
   input  logic                          req_opcode,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  nwh_pkg::dp_stat_type          dp_stat,
   output nwh_pkg::cmd_type              cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_SEG_START,
      S_SEG_END,
      S_DELTA,
      S_INIT,
      S_ROTATE,
      S_FINISH
   } state_type;

   state_type                       state_ff, state_in;
   logic [nwh_pkg::COUNT_W-1:0]     count_ff;
   nwh_pkg::addr_type               addr_ff, addr_in;
   nwh_pkg::addr_type               scan_last_ff, scan_last_in;
   logic [nwh_pkg::DRAIN_W-1:0]     drain_ff, drain_in;
   nwh_pkg::step_type               step_ff, step_in;
   logic                            few_ff, few_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            accept;
   logic                            out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      scan_last_in = (int'(count_ff) >= nwh_pkg::MAX_POINTS)
                   ? nwh_pkg::addr_type'(nwh_pkg::MAX_POINTS - 1)
                   : nwh_pkg::addr_type'(count_ff - nwh_pkg::COUNT_W'(1));
   end

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      drain_in     = drain_ff;
      step_in      = step_ff;
      few_in       = few_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      cmd              = '0;
      cmd.rd_kind      = nwh_pkg::RD_NONE;
      cmd.rd_addr      = addr_ff;
      cmd.step         = step_ff;
      cmd.few          = few_ff;
      cmd.wr_en        = accept && (req_opcode == nwh_pkg::OP_WRITE);
      cmd.capture_pose = accept && (req_opcode == nwh_pkg::OP_QUERY);
      cmd.scan_clear   = cmd.capture_pose;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_opcode == nwh_pkg::OP_QUERY)) begin
               addr_in = '0;
               if (int'(count_ff) < nwh_pkg::MIN_POINTS) begin
                  few_in   = 1'b1;
                  state_in = S_FINISH;
               end else begin
                  few_in   = 1'b0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.rd_kind = nwh_pkg::RD_SCAN;
            if (addr_ff == scan_last_ff) begin
               drain_in = nwh_pkg::DRAIN_W'(nwh_pkg::DRAIN_CYCLES - 1);
               state_in = S_DRAIN;
            end else begin
               addr_in = addr_ff + nwh_pkg::ADDR_W'(1);
            end
         end
         S_DRAIN: begin
            if (drain_ff == '0) begin
               state_in = S_SEG_START;
            end else begin
               drain_in = drain_ff - nwh_pkg::DRAIN_W'(1);
            end
         end
         S_SEG_START: begin
            cmd.rd_kind = nwh_pkg::RD_START;
            cmd.rd_addr = dp_stat.seg_start;
            state_in    = S_SEG_END;
         end
         S_SEG_END: begin
            cmd.rd_kind = nwh_pkg::RD_END;
            cmd.rd_addr = dp_stat.seg_start + nwh_pkg::ADDR_W'(1);
            state_in    = S_DELTA;
         end
         S_DELTA: begin
            state_in = S_INIT;
         end
         S_INIT: begin
            cmd.cordic_init = 1'b1;
            step_in         = '0;
            state_in        = S_ROTATE;
         end
         S_ROTATE: begin
            cmd.cordic_step = 1'b1;
            if (step_ff == nwh_pkg::step_type'(nwh_pkg::CORDIC_STEPS - 1)) begin
               state_in = S_FINISH;
            end else begin
               step_in = step_ff + nwh_pkg::step_type'(1);
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         addr_ff      <= '0;
         scan_last_ff <= '0;
         drain_ff     <= '0;
         step_ff      <= '0;
         few_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         drain_ff     <= drain_in;
         step_ff      <= step_in;
         few_ff       <= few_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            scan_last_ff <= scan_last_in;
         end
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("response valid not raised after result load");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while still held");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (addr_ff <= scan_last_ff))
      else $error("scan address beyond last waypoint in use");

   a_end_after_start: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_kind == nwh_pkg::RD_END) |-> ($past(cmd.rd_kind) == nwh_pkg::RD_START))
      else $error("segment end read without start read");

endmodule

>>> rtl/nearest_waypoint_heading_core.sv
`timescale 1ns / 1ps
// A write transaction stores one waypoint. A query transaction scans the first point_count
// waypoints (at most 64) one per cycle through the store's read port, then runs 16 CORDIC
// iterations on the chosen segment, and holds the block until its result is loaded; a query
// with fewer than two waypoints skips the scan and the CORDIC. The result sits in an output
// register, so new transactions are taken while it waits. Depends on nwh_pkg, the channel
// interfaces, nwh_ctrl and nwh_datapath.
module nearest_waypoint_heading_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [nwh_pkg::COUNT_W-1:0]   csr_wr_data,
   nwh_req_if.sink                       req,
   nwh_rsp_if.source                     rsp
);

   nwh_pkg::cmd_type     cmd;
   nwh_pkg::dp_stat_type dp_stat;

   nwh_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req.valid),
      .req_opcode  (req.opcode),
      .req_ready   (req.ready),
      .rsp_valid   (rsp.valid),
      .rsp_ready   (rsp.ready),
      .dp_stat     (dp_stat),
      .cmd         (cmd)
   );

   nwh_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_point_index (req.point_index),
      .req_point_x     (req.point_x),
      .req_point_y     (req.point_y),
      .req_pose_x      (req.pose_x),
      .req_pose_y      (req.pose_y),
      .dp_stat         (dp_stat),
      .heading         (rsp.heading),
      .segment_start   (rsp.segment_start),
      .status          (rsp.status)
   );

endmodule

>>> tb/nearest_waypoint_heading_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for nearest_waypoint_heading_core: waypoint writes, pose queries and
// path-length register settings, checked against a cycle-free predictor of the path heading.
// Depends on nwh_pkg, nwh_req_if, nwh_rsp_if and the block itself.
module nearest_waypoint_heading_core_tb;

   localparam int                 CYCLE_LIMIT = 1000000;
   localparam int                 SETTLE_CYCLES = 8;
   localparam int                 ROW_COUNT = 22;
   localparam int                 PHASE_COUNT = 12;
   localparam int                 PHASE_ITEMS = 75;
   localparam nwh_pkg::coord_type CMAX = 524287;
   localparam nwh_pkg::coord_type CMIN = -524288;

   typedef enum int {
      FLOW_FREE, FLOW_SENDER_GAPS, FLOW_SINK_STALLS, FLOW_BOTH
   } flow_mode_type;

   typedef struct packed {
      logic                        opcode;
      logic [nwh_pkg::INDEX_W-1:0] index;
      nwh_pkg::coord_type          wx;
      nwh_pkg::coord_type          wy;
      nwh_pkg::coord_type          qx;
      nwh_pkg::coord_type          qy;
   } path_op_type;

   typedef struct packed {
      logic [nwh_pkg::HEADING_W-1:0] heading;
      logic [nwh_pkg::SEG_W-1:0]     seg;
      logic                          status;
   } heading_result_type;

   typedef struct packed {
      logic                          set_count;
      logic [nwh_pkg::COUNT_W-1:0]   count;
      logic                          opcode;
      logic [nwh_pkg::INDEX_W-1:0]   index;
      nwh_pkg::coord_type            wx;
      nwh_pkg::coord_type            wy;
      nwh_pkg::coord_type            qx;
      nwh_pkg::coord_type            qy;
      logic                          typed;
      logic [nwh_pkg::HEADING_W-1:0] heading;
      logic [nwh_pkg::SEG_W-1:0]     seg;
      logic                          status;
   } directed_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [nwh_pkg::COUNT_W-1:0] csr_wr_data;

   nwh_req_if req_ch();
   nwh_rsp_if rsp_ch();

   nearest_waypoint_heading_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_ch),
      .rsp         (rsp_ch)
   );

   nwh_pkg::coord_type          path_x [nwh_pkg::MAX_POINTS];
   nwh_pkg::coord_type          path_y [nwh_pkg::MAX_POINTS];
   bit                          path_set [nwh_pkg::MAX_POINTS];
   logic [nwh_pkg::COUNT_W-1:0] path_len;
   longint                      arctan_steps [16];
   heading_result_type          awaited_headings [$];
   directed_row_type            rows [ROW_COUNT];
   flow_mode_type               flow;
   int                          error_count;
   int                          cycle_count;
   int                          writes_sent;
   int                          queries_sent;
   int                          short_path_results;
   int                          results_seen;
   int                          count_settings;

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (flow == FLOW_SINK_STALLS)
         rsp_ch.ready <= ($urandom_range(0, 99) >= 64);
      else if (flow == FLOW_BOTH)
         rsp_ch.ready <= ($urandom_range(0, 99) >= 17);
      else
         rsp_ch.ready <= 1'b1;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, what, got, want);
      error_count++;
   endtask

   always @(negedge clock) begin : check_results
      heading_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_headings.size() == 0) begin
            report_mismatch("with nothing outstanding, heading", rsp_ch.heading, 0);
         end else begin
            want = awaited_headings.pop_front();
            if (rsp_ch.heading !== want.heading)
               report_mismatch("heading", rsp_ch.heading, want.heading);
            if (rsp_ch.segment_start !== want.seg)
               report_mismatch("segment_start", rsp_ch.segment_start, want.seg);
            if (rsp_ch.status !== want.status)
               report_mismatch("status", rsp_ch.status, want.status);
            if (want.status == nwh_pkg::STATUS_FEW)
               short_path_results++;
         end
         results_seen++;
      end
   end

   function automatic logic [nwh_pkg::HEADING_W-1:0] segment_heading(input longint dx,
                                                                      input longint dy);
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      z = 0;
      if (dx == 0 && dy == 0)
         return '0;
      if (dx < 0) begin
         dx = -dx;
         dy = -dy;
         z = longint'(nwh_pkg::HALF_TURN);
      end
      x = dx * 256;
      y = dy * 256;
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + arctan_steps[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - arctan_steps[i];
         end
      end
      return nwh_pkg::HEADING_W'((z + 8 + (longint'(4) << 20)) >>> 4);
   endfunction

   function automatic heading_result_type predict_heading(input nwh_pkg::coord_type px,
                                                          input nwh_pkg::coord_type py);
      heading_result_type r;
      int     n;
      int     best;
      int     start;
      longint ex;
      longint ey;
      longint d;
      longint best_d;
      n = (path_len > nwh_pkg::MAX_POINTS) ? nwh_pkg::MAX_POINTS : int'(path_len);
      best = 0;
      best_d = 0;
      if (n < nwh_pkg::MIN_POINTS)
         return '{heading: '0, seg: '0, status: nwh_pkg::STATUS_FEW};
      for (int i = 0; i < n; i++) begin
         ex = longint'(path_x[i]) - longint'(px);
         ey = longint'(path_y[i]) - longint'(py);
         d = ex * ex + ey * ey;
         if (i == 0 || d < best_d) begin
            best = i;
            best_d = d;
         end
      end
      start = (best == 0) ? 0 : best - 1;
      r.heading = segment_heading(longint'(path_x[start + 1]) - longint'(path_x[start]),
                                  longint'(path_y[start + 1]) - longint'(path_y[start]));
      r.seg = nwh_pkg::SEG_W'(start);
      r.status = nwh_pkg::STATUS_OK;
      return r;
   endfunction

   function automatic bit sender_gap();
      if (flow == FLOW_SENDER_GAPS)
         return $urandom_range(0, 99) < 64;
      if (flow == FLOW_BOTH)
         return $urandom_range(0, 99) < 17;
      return 1'b0;
   endfunction

   function automatic nwh_pkg::coord_type draw_coord(input nwh_pkg::coord_type anchor);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         return nwh_pkg::coord_type'($urandom);
      if (pick < 75)
         return nwh_pkg::coord_type'(int'($urandom_range(0, 16)) - 8);
      return nwh_pkg::coord_type'(anchor + int'($urandom_range(0, 6)) - 3);
   endfunction

   function automatic path_op_type draw_transaction();
      path_op_type op;
      int unsigned slot;
      int          need;
      int          filled;
      slot = $urandom_range(0, nwh_pkg::MAX_POINTS - 1);
      op.opcode = ($urandom_range(0, 99) < 45) ? nwh_pkg::OP_QUERY : nwh_pkg::OP_WRITE;
      op.index = nwh_pkg::INDEX_W'($urandom);
      op.wx = nwh_pkg::coord_type'($urandom);
      op.wy = nwh_pkg::coord_type'($urandom);
      op.qx = nwh_pkg::coord_type'($urandom);
      op.qy = nwh_pkg::coord_type'($urandom);
      need = (path_len > nwh_pkg::MAX_POINTS) ? nwh_pkg::MAX_POINTS : int'(path_len);
      filled = 0;
      while (filled < nwh_pkg::MAX_POINTS && path_set[filled])
         filled++;
      // fill the path before any query reads an empty slot
      if (op.opcode == nwh_pkg::OP_QUERY && need >= nwh_pkg::MIN_POINTS && filled < need) begin
         op.opcode = nwh_pkg::OP_WRITE;
         op.index = nwh_pkg::INDEX_W'(filled);
      end
      if (op.opcode == nwh_pkg::OP_QUERY) begin
         if ($urandom_range(0, 99) < 60) begin
            op.qx = draw_coord(path_x[slot]);
            op.qy = draw_coord(path_y[slot]);
         end
      end else if (op.index != 0 && $urandom_range(0, 99) < 15) begin
         op.wx = path_x[op.index - 1];
         op.wy = path_y[op.index - 1];
      end else begin
         op.wx = draw_coord(path_x[slot]);
         op.wy = draw_coord(path_y[slot]);
      end
      return op;
   endfunction

   task automatic send_transaction(input path_op_type op, input bit typed,
                                   input heading_result_type typed_result);
      while (sender_gap()) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op.opcode;
      req_ch.point_index <= op.index;
      req_ch.point_x <= op.wx;
      req_ch.point_y <= op.wy;
      req_ch.pose_x <= op.qx;
      req_ch.pose_y <= op.qy;
      @(negedge clock);
      while (!req_ch.ready)
         @(negedge clock);
      @(posedge clock);
      if (op.opcode == nwh_pkg::OP_QUERY) begin
         awaited_headings.push_back(typed ? typed_result : predict_heading(op.qx, op.qy));
         queries_sent++;
      end else begin
         path_x[op.index] = op.wx;
         path_y[op.index] = op.wy;
         path_set[op.index] = 1'b1;
         writes_sent++;
      end
   endtask

   task automatic settle_block();
      req_ch.valid <= 1'b0;
      while (awaited_headings.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_path_length(input logic [nwh_pkg::COUNT_W-1:0] value);
      settle_block();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      path_len = value;
      count_settings++;
   endtask

   initial begin : stimulus
      path_op_type        op;
      heading_result_type typed_result;
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.opcode = nwh_pkg::OP_WRITE;
      req_ch.point_index = '0;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      req_ch.pose_x = '0;
      req_ch.pose_y = '0;
      rsp_ch.ready = 1'b0;
      flow = FLOW_FREE;
      error_count = 0;
      cycle_count = 0;
      writes_sent = 0;
      queries_sent = 0;
      short_path_results = 0;
      results_seen = 0;
      count_settings = 0;
      path_len = '0;
      for (int i = 0; i < nwh_pkg::MAX_POINTS; i++) begin
         path_x[i] = '0;
         path_y[i] = '0;
         path_set[i] = 1'b0;
      end
      arctan_steps = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
                       652, 326, 163, 81, 41, 20, 10, 5};

      rows[0]  = '{1'b1, 7'd0, nwh_pkg::OP_QUERY, 6'd17, CMIN, CMAX, CMIN, CMAX,
                   1'b1, 16'd0, 6'd0, nwh_pkg::STATUS_FEW};
      rows[1]  = '{1'b0, 7'd0, nwh_pkg::OP_WRITE, 6'd0, CMAX, CMIN, 123, -77,
                   1'b0, 16'd0, 6'd0, nwh_pkg::STATUS_OK};
      rows[2]  = '{1'b0, 7'd0, nwh_pkg::OP_WRITE, 6'd1, CMAX, CMIN, 0, 0,
                   1'b0, 16'd0, 6'd0, nwh_pkg::STATUS_OK};
      rows[3]  = '{1'b1, 7'd1, nwh_pkg::OP_QUERY, 6'd0, 0, 0, CMAX, CMAX,
                   1'b1, 16'd0, 6'd0, nwh_pkg::STATUS_FEW};
      rows[4]  = '{1'b1, 7'd2, nwh_pkg::OP_QUERY, 6'd63, CMIN, CMIN, 0, 0,
                   1'b1, 16'd0, 6'd0, nwh_pkg::STATUS_OK};
      rows[5]  = '{1'b0, 7'd0, nwh_pkg::OP_WRITE, 6'd1, CMIN, CMAX, 0, 0,
                   1'b0, 16'd0, 6'd0, nwh_pkg::STATUS_OK};
      rows[6]  = '{1'b0, 7'd0, nwh_pkg::OP_QUERY, 6'd0, 0, 0, 0, 0,
                   1'b0, 16'd0, 6'd0, nwh_pkg::STATUS_OK};
      rows[7]  = '{1'b0, 7'd0, nwh_pkg::OP_QUERY, 6'd0, 0, 0, CMAX, CMIN,
                   1'b0, 16'd0, 6'd0, nwh_pkg::STATUS_OK};
      rows[8]  = '{1'b0, 7'd0, nwh_pkg::OP_WRITE, 6'd2, CMIN, CMIN, 0, 0,
                   1'b0, 16'd0, 6'd0, nwh_pkg::STATUS_OK};
      rows[9]  = '{1'b0, 7'd0, nwh_pkg::OP_WRITE, 6'd3, 0, 0, 0, 0,
                   1'b0, 16'd0, 6'd0, nwh_pkg::STATUS_OK};
      rows[10] = '{1'b1, 7'd4, nwh_pkg::OP_QUERY, 6'd0, 0, 0, CMIN, CMIN,
                   1'b0, 16'd0, 6'd0, nwh_pkg::STATUS_OK};
      rows[11] = '{1'b0, 7'd0, nwh_pkg::OP_QUERY, 6'd0, 0, 0, 1, 1,
                   1'b0, 16'd0, 6'd0, nwh_pkg::STATUS_OK};
      rows[12] = '{1'b0, 7'd0, nwh_pkg::OP_WRITE, 6'd63, 100, 200, CMAX, CMIN,
                   1'b0, 16'd0, 6'd0, nwh_pkg::STATUS_OK};
      rows[13] = '{1'b0, 7'd0, nwh_pkg::OP_WRITE, 6'd4, 0, 1000, 0, 0,
                   1'b0, 16'd0, 6'd0, nwh_pkg::STATUS_OK};
      rows[14] = '{1'b0, 7'd0, nwh_pkg::OP_WRITE, 6'd5, -1000, 1000, 0, 0,
                   1'b0, 16'd0, 6'd0, nwh_pkg::STATUS_OK};
      rows[15] = '{1'b0, 7'd0, nwh_pkg::OP_WRITE, 6'd6, -1000, 0, 0, 0,
                   1'b0, 16'd0, 6'd0, nwh_pkg::STATUS_OK};
      rows[16] = '{1'b0, 7'd0, nwh_pkg::OP_WRITE, 6'd7, 0, -1, 0, 0,
                   1'b0, 16'd0, 6'd0, nwh_pkg::STATUS_OK};
      rows[17] = '{1'b1, 7'd8, nwh_pkg::OP_QUERY, 6'd0, 0, 0, 0, 1000,
                   1'b0, 16'd0, 6'd0, nwh_pkg::STATUS_OK};
      rows[18] = '{1'b0, 7'd0, nwh_pkg::OP_QUERY, 6'd0, 0, 0, -1000, 1000,
                   1'b0, 16'd0, 6'd0, nwh_pkg::STATUS_OK};
      rows[19] = '{1'b0, 7'd0, nwh_pkg::OP_QUERY, 6'd0, 0, 0, -1000, 0,
                   1'b0, 16'd0, 6'd0, nwh_pkg::STATUS_OK};
      rows[20] = '{1'b0, 7'd0, nwh_pkg::OP_QUERY, 6'd0, 0, 0, 0, -1,
                   1'b0, 16'd0, 6'd0, nwh_pkg::STATUS_OK};
      rows[21] = '{1'b0, 7'd0, nwh_pkg::OP_QUERY, 6'd42, CMAX, CMIN, CMIN, CMAX,
                   1'b0, 16'd0, 6'd0, nwh_pkg::STATUS_OK};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < ROW_COUNT; r++) begin
         if (rows[r].set_count)
            set_path_length(rows[r].count);
         op = '{rows[r].opcode, rows[r].index, rows[r].wx, rows[r].wy, rows[r].qx, rows[r].qy};
         typed_result = '{rows[r].heading, rows[r].seg, rows[r].status};
         send_transaction(op, rows[r].typed, typed_result);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0, 7, 11: set_path_length(7'd64);
            1:        set_path_length(7'd2);
            2:        set_path_length(7'd127);
            3:        set_path_length(7'd3);
            4:        set_path_length(7'd65);
            5:        set_path_length(7'd1);
            6:        set_path_length(nwh_pkg::COUNT_W'($urandom_range(4, 63)));
            8:        set_path_length(7'd0);
            9:        set_path_length(nwh_pkg::COUNT_W'($urandom_range(2, 10)));
            default:  set_path_length(7'd100);
         endcase
         flow = flow_mode_type'(p % 4);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // hold the sender until every outstanding query has answered
            if ((p == 5 || p == 9) && k == 40)
               settle_block();
            send_transaction(draw_transaction(), 1'b0, '0);
         end
      end

      settle_block();
      repeat (100) @(posedge clock);
      $display("Covered %0d waypoint writes and %0d pose queries over %0d path-length settings,",
               writes_sent, queries_sent, count_settings);
      $display("%0d results checked, %0d of them short-path, %0d mismatches.",
               results_seen, short_path_results, error_count);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> files.f
rtl/nwh_pkg.sv
rtl/nwh_req_if.sv
rtl/nwh_rsp_if.sv
rtl/nwh_ram.sv
rtl/nwh_datapath.sv
rtl/nwh_ctrl.sv
rtl/nearest_waypoint_heading_core.sv
tb/nearest_waypoint_heading_core_tb.sv
